/* rtl/assert_macros.svh */
// Assertion macros used by the top level of the shelf rectangle packer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition on one edge implies another on the next edge
`define ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

/* rtl/spr_pkg.sv */
// Shared types and constants of the shelf rectangle packer
`timescale 1ns / 1ps

package spr_pkg;

    // Field widths
    localparam int DIM_W = 13;
    localparam int POS_W = 12;

    // Defaults and limits
    localparam int MAX_SHELVES_DEF = 64;
    localparam int MAX_DIM         = 4096;
    localparam logic [DIM_W-1:0] RESET_ATLAS_WIDTH = 13'd256;

    // Configuration register indexes
    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    // One shelf table entry as held in memory
    typedef struct packed {
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] used;
        logic [DIM_W-1:0] tall;
    } shelf_t;

    localparam int SHELF_W = $bits(shelf_t);

    // Decision for one shelf against the current request
    typedef struct packed {
        logic             take;
        logic [DIM_W-1:0] new_used;
        logic [DIM_W-1:0] new_tall;
    } fit_t;

endpackage

/* rtl/spr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps

module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry; read one entry into the registered output, valid in the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/spr_shelf_eval.sv */
// Fit test of one shelf entry against the pending request
`timescale 1ns / 1ps

module spr_shelf_eval
    import spr_pkg::*;
(
    input  shelf_t           shelf,
    input  logic [DIM_W-1:0] req_w,
    input  logic [DIM_W-1:0] req_h,
    input  logic [DIM_W-1:0] atlas_w,
    input  logic [DIM_W-1:0] atlas_h,
    input  logic             is_last,
    output fit_t             fit
);

    logic [DIM_W:0] sum_w;
    logic [DIM_W:0] sum_h;
    logic           fit_w;
    logic           tall_ok;
    logic           raise_ok;

    // Width left on the shelf, height and room to raise the last shelf
    always_comb
    begin
        sum_w    = {1'b0, shelf.used} + {1'b0, req_w};
        sum_h    = {1'b0, shelf.top} + {1'b0, req_h};
        fit_w    = (sum_w <= {1'b0, atlas_w}) || (req_w == '0);
        tall_ok  = (shelf.tall >= req_h);
        raise_ok = (sum_h <= {1'b0, atlas_h}) || (req_h == '0);

        fit.take     = fit_w && (tall_ok || (is_last && raise_ok));
        fit.new_used = sum_w[DIM_W-1:0];
        fit.new_tall = tall_ok ? shelf.tall : req_h;
    end

endmodule

/* rtl/shelf_rectangle_packer.sv */
// Top level of the shelf rectangle packer: request control, shelf scan and result register
// An oversized request fails at once; else the open shelves are tested in order, one shelf tested a
// cycle, until one takes it, and a new shelf is appended when none does or none is open. The next
// request is taken only in S_IDLE, from the edge at which the last result can first be taken; a stalled
// result holds the following result in S_DONE and so holds off the request after that. Reset clears
// the shelf count, sets atlas_width to 256 and atlas_height to 0; shelf memory is not cleared.
`timescale 1ns / 1ps

module shelf_rectangle_packer
    import spr_pkg::*;
#(
    parameter int MAX_SHELVES = MAX_SHELVES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [12:0] req_width, [25:13] req_height, [31:26] zero
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] placed, [12:1] pos_x, [24:13] pos_y, [31:25] zero
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata
);

    localparam int IW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int CW = $clog2(MAX_SHELVES + 1);
    localparam logic [CW-1:0] CountMax = CW'(MAX_SHELVES);
    localparam logic [16:0]   MaxDimC  = 17'(MAX_DIM);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_APPEND = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [DIM_W-1:0] atlas_w_reg, atlas_h_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic [IW-1:0]    eval_reg, eval_next;
    logic             dvalid_reg, dvalid_next;
    logic [DIM_W-1:0] req_w_reg, req_w_next;
    logic [DIM_W-1:0] req_h_reg, req_h_next;
    logic [DIM_W:0]   base_y_reg, base_y_next;
    logic             res_ok_reg, res_ok_next;
    logic [POS_W-1:0] res_x_reg, res_x_next;
    logic [POS_W-1:0] res_y_reg, res_y_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_ok_reg;
    logic [POS_W-1:0] out_x_reg, out_y_reg;

    logic [DIM_W-1:0] in_w, in_h;
    logic             in_accept;
    logic             oversize;
    logic             rd_en;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    shelf_t           wr_data;
    shelf_t           rd_shelf;
    logic [SHELF_W-1:0] rd_data;
    logic             is_last;
    fit_t             fit;
    logic             out_free;
    logic [DIM_W+1:0] new_bottom;
    logic             append_ok;

    assign in_w      = s_tdata[12:0];
    assign in_h      = s_tdata[25:13];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign rd_shelf  = shelf_t'(rd_data);
    assign is_last   = (({1'b0, CW'(eval_reg)}) + 1'b1) == {1'b0, count_reg};
    assign out_free  = !out_valid_reg || m_tready;

    // Oversized requests fail without touching the shelf table
    assign oversize = (in_w > atlas_w_reg) || (in_h > atlas_h_reg)
                   || ({4'b0, in_w} > MaxDimC) || ({4'b0, in_h} > MaxDimC);

    // New shelf fits below the last one if its bottom stays within the atlas and the table is not full
    assign new_bottom = {1'b0, base_y_reg} + {2'b0, req_h_reg};
    assign append_ok  = (new_bottom <= {2'b0, atlas_h_reg}) && (count_reg != CountMax);

    spr_ram #(
        .WIDTH (SHELF_W),
        .DEPTH (MAX_SHELVES)
    ) u_shelf_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IW-1:0]),
        .rd_data (rd_data)
    );

    spr_shelf_eval u_eval (
        .shelf   (rd_shelf),
        .req_w   (req_w_reg),
        .req_h   (req_h_reg),
        .atlas_w (atlas_w_reg),
        .atlas_h (atlas_h_reg),
        .is_last (is_last),
        .fit     (fit)
    );

    // Sequence one request: scan shelves, append, then hand over the result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        eval_next      = eval_reg;
        dvalid_next    = 1'b0;
        req_w_next     = req_w_reg;
        req_h_next     = req_h_reg;
        base_y_next    = base_y_reg;
        res_ok_next    = res_ok_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = eval_reg;
        wr_data        = '{top: rd_shelf.top, used: fit.new_used, tall: fit.new_tall};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_w_next  = in_w;
                    req_h_next  = in_h;
                    issue_next  = '0;
                    base_y_next = '0;
                    res_ok_next = 1'b0;
                    res_x_next  = '0;
                    res_y_next  = '0;
                    priority if (oversize)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_APPEND;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue the next read while the previous entry is tested
                if (issue_reg < count_reg)
                begin
                    rd_en       = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                    eval_next   = issue_reg[IW-1:0];
                    dvalid_next = 1'b1;
                end
                if (dvalid_reg)
                begin
                    if (fit.take)
                    begin
                        wr_en       = 1'b1;
                        res_ok_next = 1'b1;
                        res_x_next  = rd_shelf.used[POS_W-1:0];
                        res_y_next  = rd_shelf.top[POS_W-1:0];
                        dvalid_next = 1'b0;
                        state_next  = S_DONE;
                    end
                    else if (is_last)
                    begin
                        base_y_next = {1'b0, rd_shelf.top} + {1'b0, rd_shelf.tall};
                        dvalid_next = 1'b0;
                        state_next  = S_APPEND;
                    end
                end
            end
            S_APPEND:
            begin
                // Open a new shelf below the last one
                if (append_ok)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = count_reg[IW-1:0];
                    wr_data     = '{top: base_y_reg[DIM_W-1:0], used: req_w_reg,
                                    tall: req_h_reg};
                    count_next  = count_reg + 1'b1;
                    res_ok_next = 1'b1;
                    res_x_next  = '0;
                    res_y_next  = base_y_reg[POS_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            atlas_w_reg   <= RESET_ATLAS_WIDTH;
            atlas_h_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            dvalid_reg    <= dvalid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ATLAS_WIDTH:  atlas_w_reg <= cfg_wdata;
                    REG_ATLAS_HEIGHT: atlas_h_reg <= cfg_wdata;
                    default:          atlas_w_reg <= atlas_w_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        eval_reg   <= eval_next;
        req_w_reg  <= req_w_next;
        req_h_reg  <= req_h_next;
        base_y_reg <= base_y_next;
        res_ok_reg <= res_ok_next;
        res_x_reg  <= res_x_next;
        res_y_reg  <= res_y_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_ok_reg <= res_ok_reg;
            out_x_reg  <= res_x_reg;
            out_y_reg  <= res_y_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_y_reg, out_x_reg, out_ok_reg};

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CountMax, "shelf count above table size")
    `ASSERT_ALWAYS(a_issue_bound, issue_reg <= count_reg, "shelf read beyond open shelves")
    `ASSERT_NEXT(a_count_only_append, state_reg != S_APPEND, $stable(count_reg), "count moved")
    `ASSERT_ALWAYS(a_fail_zero, !m_tvalid || out_ok_reg || m_tdata[24:1] == '0, "bad failure")

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the shelf rectangle packer: directed table, then random requests
`timescale 1ns / 1ps

module testbench
    import spr_pkg::*;
();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 20;
    localparam int PHASE_ITEMS  = 85;
    localparam int CALM_PHASES  = 3;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 100;
    localparam int HOLD_PHASE   = 5;
    localparam int PAUSE_PHASE  = 8;

    // Result fields, laid out as in m_tdata from bit 0 up: placed, pos_x, pos_y
    typedef struct packed {
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_x;
        logic             placed;
    } placement_t;

    // One row of the directed table: a register write or a request
    typedef struct packed {
        logic       is_cfg;
        logic       reg_idx;
        int         arg_a;
        int         arg_b;
        logic       typed;
        placement_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_wdata;

    // Shelf model state and configuration
    logic [DIM_W-1:0] atlas_w;
    logic [DIM_W-1:0] atlas_h;
    logic [DIM_W-1:0] shelf_y    [MAX_SHELVES_DEF];
    logic [DIM_W-1:0] shelf_fill [MAX_SHELVES_DEF];
    logic [DIM_W-1:0] shelf_h    [MAX_SHELVES_DEF];
    int               shelf_cnt;

    placement_t placement_q[$];
    int         mismatches;
    bit         idle_on;
    bit         long_hold_req;

    shelf_rectangle_packer #(
        .MAX_SHELVES(MAX_SHELVES_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    function automatic int spare_room(int limit, int taken);
        return (taken > limit) ? 0 : limit - taken;
    endfunction

    // First-fit shelf placement of one request; updates the shelf table
    function automatic placement_t place_rect(int w, int h);
        placement_t res;
        int         new_y;
        res = '0;
        if (w > int'(atlas_w) || h > int'(atlas_h) || w > MAX_DIM || h > MAX_DIM)
            return res;
        for (int i = 0; i < shelf_cnt; i++)
        begin
            if (spare_room(int'(atlas_w), int'(shelf_fill[i])) < w)
                continue;
            // A shorter shelf may only take it if it is the last and can be raised
            if (int'(shelf_h[i]) < h)
            begin
                if (i + 1 != shelf_cnt)
                    continue;
                if (spare_room(int'(atlas_h), int'(shelf_y[i])) < h)
                    continue;
                shelf_h[i] = h[DIM_W-1:0];
            end
            res.placed = 1'b1;
            res.pos_x  = shelf_fill[i][POS_W-1:0];
            res.pos_y  = shelf_y[i][POS_W-1:0];
            shelf_fill[i] = shelf_fill[i] + w[DIM_W-1:0];
            return res;
        end
        // Open a new shelf below the last one
        new_y = 0;
        if (shelf_cnt > 0)
            new_y = int'(shelf_y[shelf_cnt-1]) + int'(shelf_h[shelf_cnt-1]);
        if (new_y > int'(atlas_h) || h > int'(atlas_h) - new_y)
            return res;
        if (shelf_cnt >= MAX_SHELVES_DEF)
            return res;
        shelf_y[shelf_cnt]    = new_y[DIM_W-1:0];
        shelf_fill[shelf_cnt] = w[DIM_W-1:0];
        shelf_h[shelf_cnt]    = h[DIM_W-1:0];
        shelf_cnt++;
        res.placed = 1'b1;
        res.pos_y  = new_y[POS_W-1:0];
        return res;
    endfunction

    function automatic stim_row_t req_row(int w, int h);
        stim_row_t row;
        row = '0;
        row.arg_a = w;
        row.arg_b = h;
        return row;
    endfunction

    function automatic stim_row_t typed_row(int w, int h, bit ok, int x, int y);
        stim_row_t row;
        row = req_row(w, h);
        row.typed       = 1'b1;
        row.want.placed = ok;
        row.want.pos_x  = x[POS_W-1:0];
        row.want.pos_y  = y[POS_W-1:0];
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic idx, int value);
        stim_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.arg_a   = value;
        return row;
    endfunction

    task automatic report(string field, int got, int exp);
        $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, exp, $time);
        mismatches++;
    endtask

    // Write one register; valid is left high and lowered by the next request
    task automatic write_reg(logic idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[12:0];
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_ATLAS_WIDTH)
            atlas_w = value[DIM_W-1:0];
        else
            atlas_h = value[DIM_W-1:0];
    endtask

    // Offer one request, with an optional gap before it, and queue its expected result
    task automatic send_request(int w, int h, logic typed, placement_t want);
        placement_t predicted;
        cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, h[12:0], w[12:0]};
        do @(posedge clk); while (!s_tready);
        predicted = place_rect(w, h);
        placement_q.push_back(typed ? want : predicted);
    endtask

    // Hold off requests until every expected result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, one long hold on request, and checking
    initial
    begin
        int         stall_left;
        placement_t got;
        placement_t want;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[24:0];
                if (placement_q.size() == 0)
                    report("unexpected result", int'(m_tdata), 0);
                else
                begin
                    want = placement_q.pop_front();
                    if (got.placed != want.placed)
                        report("placed", got.placed, want.placed);
                    if (got.pos_x != want.pos_x)
                        report("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_y != want.pos_y)
                        report("pos_y", got.pos_y, want.pos_y);
                end
                if (m_tdata[31:25] != '0)
                    report("tdata padding", m_tdata[31:25], 0);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_tready     <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                m_tready  <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        stim_row_t directed_rows[$];
        int        aw;
        int        ah;
        int        w;
        int        h;
        int        stack;
        int        sel;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ATLAS_WIDTH;
        cfg_wdata <= '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        mismatches    = 0;
        atlas_w       = RESET_ATLAS_WIDTH;
        atlas_h       = '0;
        shelf_cnt     = 0;

        // Reset values: width 256, height 0, so only zero-height requests fit
        directed_rows.push_back(typed_row(256, 0, 1'b1, 0, 0));
        directed_rows.push_back(typed_row(257, 0, 1'b0, 0, 0));
        directed_rows.push_back(typed_row(0, 1, 1'b0, 0, 0));
        directed_rows.push_back(cfg_row(REG_ATLAS_WIDTH, 4096));
        directed_rows.push_back(typed_row(3840, 0, 1'b1, 256, 0));
        // Used width reaches 4096, so the next x wraps to zero in 12 bits
        directed_rows.push_back(typed_row(0, 0, 1'b1, 0, 0));
        directed_rows.push_back(typed_row(4096, 4096, 1'b0, 0, 0));
        directed_rows.push_back(cfg_row(REG_ATLAS_HEIGHT, 4096));
        directed_rows.push_back(req_row(1, 1));
        // Raise the last shelf
        directed_rows.push_back(req_row(4095, 2));
        directed_rows.push_back(req_row(1, 1));
        directed_rows.push_back(req_row(4096, 1));
        // Shrink the atlas below the shelf tops
        directed_rows.push_back(cfg_row(REG_ATLAS_HEIGHT, 2));
        directed_rows.push_back(req_row(0, 2));
        directed_rows.push_back(req_row(1, 1));
        directed_rows.push_back(req_row(5, 2));
        directed_rows.push_back(cfg_row(REG_ATLAS_WIDTH, 1));
        directed_rows.push_back(req_row(1, 0));
        directed_rows.push_back(req_row(0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_cfg)
            begin
                drain();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].arg_a);
            end
            else
                send_request(directed_rows[k].arg_a, directed_rows[k].arg_b,
                             directed_rows[k].typed, directed_rows[k].want);
        end

        // Random phases, each with its own atlas setting
        for (int p = 0; p < PHASES; p++)
        begin
            idle_on = (p < PHASES - CALM_PHASES) && (p % 4 != 3);
            drain();
            stack = 0;
            if (shelf_cnt > 0)
                stack = int'(shelf_y[shelf_cnt-1]) + int'(shelf_h[shelf_cnt-1]);
            case ($urandom_range(0, 5))
                0:       aw = 1;
                1:       aw = MAX_DIM;
                2:       aw = 256;
                default: aw = $urandom_range(16, 1024);
            endcase
            case ($urandom_range(0, 7))
                0:       ah = 0;
                1:       ah = MAX_DIM;
                2:       ah = $urandom_range(0, stack);
                default: ah = stack + $urandom_range(16, 400);
            endcase
            if (ah > MAX_DIM)
                ah = MAX_DIM;
            write_reg(REG_ATLAS_WIDTH, aw);
            write_reg(REG_ATLAS_HEIGHT, ah);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Stall the result side long enough to back up the request side
                if (p == HOLD_PHASE && k == 30)
                    long_hold_req = 1'b1;
                if (p == PAUSE_PHASE && k == 40)
                    drain();
                sel = $urandom_range(0, 19);
                if (sel < 12)
                    w = $urandom_range(0, aw / 4 + 1);
                else if (sel < 15)
                    w = $urandom_range(0, aw);
                else if (sel < 17)
                    w = aw;
                else if (sel < 19 && aw < MAX_DIM)
                    w = $urandom_range(aw + 1, MAX_DIM);
                else
                    w = 0;
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    h = $urandom_range(0, 24);
                else if (sel < 17)
                    h = $urandom_range(0, 64);
                else if (ah < MAX_DIM)
                    h = $urandom_range(ah + 1, MAX_DIM);
                else
                    h = $urandom_range(0, 24);
                send_request(w, h, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_ram.sv
rtl/spr_shelf_eval.sv
rtl/shelf_rectangle_packer.sv
sim/testbench.sv
